/* sv/kmd_pkg.sv */
package kmd_pkg;

	localparam int unsigned MATRIX_W = 16;
	localparam int unsigned KEY_W    = 7;
	localparam int unsigned COUNT_W  = 4;

	localparam logic [KEY_W-1:0]   NONE_KEY  = 7'h5A;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
	localparam logic [COUNT_W-1:0] CONFIRM_RESET = 4'd2;

	// ASCII legend in row-major order: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
	localparam logic [KEY_W-1:0] LEGEND [MATRIX_W] = '{
		7'h31, 7'h32, 7'h33, 7'h41,
		7'h34, 7'h35, 7'h36, 7'h42,
		7'h37, 7'h38, 7'h39, 7'h43,
		7'h2A, 7'h30, 7'h23, 7'h44
	};

	// Decoded scan handed to the debounce logic
	typedef struct packed {
		logic             contact;
		logic [KEY_W-1:0] key;
	} kmd_scan_t;

	// One result item
	typedef struct packed {
		logic [KEY_W-1:0] latched_key;
		logic             key_typed;
		logic             any_contact;
	} kmd_result_t;

endpackage

/* sv/kmd_scan_if.sv */
interface kmd_scan_if;
	import kmd_pkg::*;

	logic                valid;
	logic                ready;
	logic [MATRIX_W-1:0] contact_matrix;

	modport source (output valid, output contact_matrix, input ready);
	modport sink (input valid, input contact_matrix, output ready);

endinterface

/* sv/kmd_result_if.sv */
interface kmd_result_if;
	import kmd_pkg::*;

	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] latched_key;
	logic             key_typed;
	logic             any_contact;

	modport source (output valid, output latched_key, output key_typed, output any_contact,
		input ready);
	modport sink (input valid, input latched_key, input key_typed, input any_contact,
		output ready);

endinterface

/* sv/kmd_decode.sv */
module kmd_decode (
	input  logic [kmd_pkg::MATRIX_W-1:0] matrix,
	output kmd_pkg::kmd_scan_t           scan
);
	import kmd_pkg::*;

	logic [$clog2(MATRIX_W)-1:0] pos;

	// Find the lowest closed contact; scan from the top so the lowest wins
	always_comb begin
		pos = '1;
		for (int i = MATRIX_W - 1; i >= 0; i--) begin
			if (matrix[i]) begin
				pos = ($clog2(MATRIX_W))'(i);
			end
		end
	end

	// Map position to legend
	always_comb begin
		scan.contact = |matrix;
		scan.key     = LEGEND[pos];
	end

endmodule

/* sv/kmd_debounce.sv */
module kmd_debounce (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [kmd_pkg::COUNT_W-1:0] confirm_scans,
	input  kmd_pkg::kmd_scan_t          scan,
	output kmd_pkg::kmd_result_t        result
);
	import kmd_pkg::*;

	logic [KEY_W-1:0]   cand_q;
	logic [KEY_W-1:0]   acc_q;
	logic [COUNT_W-1:0] cnt_q;

	logic [COUNT_W:0]   limit_wide;
	logic [COUNT_W-1:0] limit;
	logic [COUNT_W-1:0] cnt_nxt;
	logic [KEY_W-1:0]   cand_nxt;
	logic               typed;

	// Saturation limit: confirm_scans + 1, capped at the counter maximum
	assign limit_wide = {1'b0, confirm_scans} + (COUNT_W+1)'(1);
	assign limit      = (limit_wide > {1'b0, COUNT_MAX}) ? COUNT_MAX : limit_wide[COUNT_W-1:0];

	// Next candidate and count
	always_comb begin
		cnt_nxt  = cnt_q;
		cand_nxt = cand_q;
		if (!scan.contact) begin
			cnt_nxt  = '0;
			cand_nxt = NONE_KEY;
		end else if (scan.key == cand_q) begin
			if (cnt_q < limit) begin
				cnt_nxt = cnt_q + COUNT_W'(1);
			end
		end else begin
			cnt_nxt  = COUNT_W'(1);
			cand_nxt = scan.key;
		end
	end

	assign typed = scan.contact && (cnt_nxt == confirm_scans);

	// Result seen by the output register
	always_comb begin
		result.latched_key = typed ? scan.key : acc_q;
		result.key_typed   = typed;
		result.any_contact = scan.contact;
	end

	// Advance state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= NONE_KEY;
			cnt_q  <= '0;
			acc_q  <= NONE_KEY;
		end else if (advance) begin
			cand_q <= cand_nxt;
			cnt_q  <= cnt_nxt;
			if (typed) begin
				acc_q <= scan.key;
			end
		end
	end

endmodule

/* sv/keypad_matrix_debounce.sv */
// 4x4 keypad scan debouncer.
// scan (valid/ready) carries one full contact snapshot per item, bit row*4+col.
// result (valid/ready) carries one item per scan: latched_key (ASCII of the last
// accepted key, 'Z' before any), key_typed (key accepted on this scan) and
// any_contact. cfg_we/cfg_wdata write confirm_scans, the number of identical
// scans needed to accept a key; write it only while no scan is in flight.
// A scan accepted into the input register is decoded and debounced
// combinationally, and the result register captures it when the pipe advances.
// Throughput: one scan per cycle while result is not stalled; the input register
// and the result register form a two-stage pipeline whose only loop is the state update.
// When result is stalled the result register holds, the input register keeps
// one more scan, and scan.ready drops only when both are full.
// Reset clears both pipeline stages, sets candidate and latched key to 'Z',
// the stability count to zero and confirm_scans to 2.
module keypad_matrix_debounce (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [kmd_pkg::COUNT_W-1:0] cfg_wdata,
	kmd_scan_if.sink                    scan,
	kmd_result_if.source                result
);
	import kmd_pkg::*;

	logic [COUNT_W-1:0]  confirm_q;
	logic                vld_s1;
	logic [MATRIX_W-1:0] matrix_s1;
	logic                vld_s2;
	kmd_result_t         res_s2;

	kmd_scan_t           dec;
	kmd_result_t         res_nxt;
	logic                advance;
	logic                take;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_q <= CONFIRM_RESET;
		end else if (cfg_we) begin
			confirm_q <= cfg_wdata;
		end
	end

	// Pipeline handshake
	assign advance    = vld_s1 && (!vld_s2 || result.ready);
	assign scan.ready = !vld_s1 || advance;
	assign take       = scan.valid && scan.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (scan.ready) begin
			vld_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			matrix_s1 <= scan.contact_matrix;
		end
	end

	kmd_decode u_decode (
		.matrix (matrix_s1),
		.scan   (dec)
	);

	kmd_debounce u_debounce (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.confirm_scans (confirm_q),
		.scan          (dec),
		.result        (res_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || result.ready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid       = vld_s2;
	assign result.latched_key = res_s2.latched_key;
	assign result.key_typed   = res_s2.key_typed;
	assign result.any_contact = res_s2.any_contact;

	// A typed key needs a closed contact
	a_typed_contact: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.key_typed) |-> res_s2.any_contact)
		else $error("key typed without contact");

	// A typed key is always a real legend, never the none marker
	a_typed_key: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.key_typed) |-> (res_s2.latched_key != NONE_KEY))
		else $error("typed key is the none marker");

	// Input stalls only when both stages are full and the output is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!scan.ready |-> (vld_s1 && vld_s2 && !result.ready))
		else $error("input stalled without a full pipeline");

endmodule

/* tb/sv/keypad_matrix_debounce_test.sv */
`timescale 1ns / 1ps

module keypad_matrix_debounce_test;
	import kmd_pkg::*;

	// Debounce tracker: mirrors candidate, count and latched key, queues expected items
	class debounce_tracker;
		logic [COUNT_W-1:0] confirm_scans;
		logic [KEY_W-1:0]   candidate;
		logic [COUNT_W-1:0] stable_count;
		logic [KEY_W-1:0]   accepted;
		kmd_result_t        pending[$];
		int                 errors;

		function new();
			confirm_scans = CONFIRM_RESET;
			candidate     = NONE_KEY;
			stable_count  = '0;
			accepted      = NONE_KEY;
			errors        = 0;
		endfunction

		function void set_confirm(logic [COUNT_W-1:0] value);
			confirm_scans = value;
		endfunction

		// Decode one accepted scan and queue the result item it causes
		function void note_scan(logic [MATRIX_W-1:0] snap);
			kmd_result_t want;
			int          pos;
			int          limit;
			logic [KEY_W-1:0] key;
			want.key_typed   = 1'b0;
			want.any_contact = |snap;
			if (snap != '0) begin
				// first closed contact in row-major order; bit 15 needs no test
				pos = 0;
				while (pos < MATRIX_W - 1 && !snap[pos])
					pos++;
				key = LEGEND[pos];
				limit = int'(confirm_scans) + 1;
				if (limit > int'(COUNT_MAX))
					limit = int'(COUNT_MAX);
				if (key == candidate) begin
					if (int'(stable_count) < limit)
						stable_count = stable_count + 1'b1;
				end else begin
					stable_count = COUNT_W'(1);
					candidate    = key;
				end
				if (stable_count == confirm_scans) begin
					accepted       = key;
					want.key_typed = 1'b1;
				end
			end else begin
				stable_count = '0;
				candidate    = NONE_KEY;
			end
			want.latched_key = accepted;
			pending.push_back(want);
		endfunction

		// Compare one result item with the oldest expectation
		function void check_result(kmd_result_t got);
			kmd_result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result item: latched_key %h key_typed %b any_contact %b",
						got.latched_key, got.key_typed, got.any_contact);
				return;
			end
			want = pending.pop_front();
			if (got.latched_key !== want.latched_key || got.key_typed !== want.key_typed ||
				got.any_contact !== want.any_contact) begin
				errors++;
				if (errors <= 10)
					$display(
						"mismatch: key exp %h got %h, typed exp %b got %b, contact exp %b got %b",
						want.latched_key, got.latched_key, want.key_typed, got.key_typed,
						want.any_contact, got.any_contact);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	kmd_scan_if   scan_if();
	kmd_result_if result_if();

	debounce_tracker tracker = new();

	// Shared pacing controls
	bit steady_flow;
	bit hold_request;

	keypad_matrix_debounce dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.scan      (scan_if),
		.result    (result_if)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Give up after a generous fixed time
	initial begin
		#2ms;
		$display("keypad_matrix_debounce verification failed");
		$finish;
	end

	// Result side: check accepted items, stall at random or for a long hold-off
	initial begin
		int hold_left;
		kmd_result_t got;
		hold_left = 0;
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_if.valid && result_if.ready) begin
				got.latched_key = result_if.latched_key;
				got.key_typed   = result_if.key_typed;
				got.any_contact = result_if.any_contact;
				tracker.check_result(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = 64;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (steady_flow) begin
				result_if.ready <= 1'b1;
			end else begin
				result_if.ready <= ($urandom_range(99) >= 29);
			end
		end
	end

	// Offer one scan, idling first at random, and wait for it to be taken
	task automatic send_scan(input logic [MATRIX_W-1:0] snap);
		while (!steady_flow && $urandom_range(99) < 29) begin
			scan_if.valid <= 1'b0;
			@(posedge clk);
		end
		scan_if.valid          <= 1'b1;
		scan_if.contact_matrix <= snap;
		@(posedge clk);
		while (!scan_if.ready)
			@(posedge clk);
		tracker.note_scan(snap);
	endtask

	// Stop offering and wait for every expected item to come back
	task automatic drain;
		scan_if.valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write confirm_scans while nothing is in flight
	task automatic write_confirm(input logic [COUNT_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_confirm(value);
	endtask

	// Mostly held keys with chatter further down the scan order, plus releases and noise
	task automatic play_scans(input int count);
		int sent;
		int pos;
		int run;
		int pick;
		logic [31:0] above;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				pos   = $urandom_range(MATRIX_W - 1);
				above = 32'hFFFF << (pos + 1);
				run   = $urandom_range(1, int'(tracker.confirm_scans) + 3);
				repeat (run) begin
					if ($urandom_range(3) == 0)
						send_scan(16'(32'h1 << pos) | (16'($urandom) & above[15:0]));
					else
						send_scan(16'(32'h1 << pos));
					sent++;
				end
				if ($urandom_range(1) == 0) begin
					send_scan('0);
					sent++;
				end
			end else if (pick < 85) begin
				send_scan('0);
				sent++;
			end else begin
				send_scan(16'($urandom));
				sent++;
			end
		end
	endtask

	// Main sequence
	initial begin
		logic [MATRIX_W-1:0] directed [21] = '{
			16'h0000, 16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h8000, 16'h8000,
			16'hFFFF, 16'hFFFF, 16'h1000, 16'h1000, 16'h4000, 16'h4000, 16'h0008,
			16'h0008, 16'hF0F0, 16'hF0F0, 16'h2000, 16'h0002, 16'h0002, 16'h0000
		};
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		scan_if.valid          = 1'b0;
		scan_if.contact_matrix = '0;
		steady_flow            = 1'b0;
		hold_request           = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset setting, extreme contacts, priority among several keys
		foreach (directed[i])
			send_scan(directed[i]);

		// Accept on first scan; long result stall fills the pipe
		write_confirm(4'd1);
		play_scans(100);
		hold_request = 1'b1;
		play_scans(100);

		// Longest meaningful confirm, with a stretch of no idling
		write_confirm(4'd14);
		steady_flow = 1'b1;
		play_scans(150);
		steady_flow = 1'b0;
		play_scans(50);

		// Zero never accepts; pause mid-phase until all results are in
		write_confirm(4'd0);
		play_scans(100);
		drain();
		play_scans(100);

		// Fifteen accepts when the capped count reaches 15 and again on each further identical scan
		write_confirm(4'd15);
		play_scans(250);

		write_confirm(4'd3);
		play_scans(200);

		write_confirm(4'($urandom_range(1, 14)));
		play_scans(200);

		write_confirm(4'd2);
		play_scans(350);

		drain();
		if (tracker.errors == 0 && tracker.pending.size() == 0)
			$display("keypad_matrix_debounce verification clean");
		else
			$display("keypad_matrix_debounce verification failed");
		$finish;
	end

endmodule
